### hdl/chip8_pkg.sv
// chip8_pkg: shared types, opcode and status codes, font ROM and helper functions
// for the CHIP-8 interpreter core. No dependencies.
package chip8_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCREEN_ROWS_DEF = 32;

    localparam int ADDR_W     = 12;
    localparam int FONT_BYTES = 80;
    localparam int CNT_W      = 7;

    localparam logic [ADDR_W-1:0] START_ADDR = 12'h200;

    // item modes
    localparam logic [2:0] MODE_LOAD = 3'd0;
    localparam logic [2:0] MODE_KEY  = 3'd1;
    localparam logic [2:0] MODE_TICK = 3'd2;
    localparam logic [2:0] MODE_EXEC = 3'd3;
    localparam logic [2:0] MODE_ROW  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BAD   = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_UNDER = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;

    // opcode top nibbles
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEQI  = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SEQ   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNE   = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] F_GETDT = 8'h07;
    localparam logic [7:0] F_WAITK = 8'h0A;
    localparam logic [7:0] F_SETDT = 8'h15;
    localparam logic [7:0] F_SETST = 8'h18;
    localparam logic [7:0] F_ADDI  = 8'h1E;
    localparam logic [7:0] F_FONT  = 8'h29;
    localparam logic [7:0] F_BCD   = 8'h33;
    localparam logic [7:0] F_STORE = 8'h55;
    localparam logic [7:0] F_LOAD  = 8'h65;

    localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] address;
        logic [7:0]  data;
        logic [3:0]  key_index;
        logic        key_down;
        logic [4:0]  row_select;
        logic [7:0]  random_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] program_counter;
        logic        collision;
        logic [63:0] display_row;
        logic [7:0]  delay_value;
    } result_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_ROW,
        S_FETCH_HI,
        S_FETCH_LO,
        S_EXEC,
        S_FLAG_WR,
        S_CLEAR,
        S_RET,
        S_DRAW_RD,
        S_DRAW_WR,
        S_BCD,
        S_STORE_RD,
        S_STORE_WR,
        S_LOAD_RD,
        S_LOAD_WR,
        S_RESP
    } state_t;

    // {found, lowest pressed key}
    function automatic logic [4:0] lowest_key(input logic [15:0] keys);
        logic [4:0] r;
        r = '0;
        for (int k = 15; k >= 0; k--) begin
            if (keys[k]) begin
                r = {1'b1, 4'(k)};
            end
        end
        return r;
    endfunction

    // {hundreds, tens, ones}; tens via reciprocal 205/2048, exact for every 7-bit remainder
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [7:0]  r;
        logic [3:0]  h;
        logic [3:0]  t;
        logic [14:0] p;
        logic [6:0]  o;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        p = 15'(r[6:0]) * 15'd205;
        t = p[14:11];
        o = r[6:0] - {t, 3'b000} - {2'b00, t, 1'b0};
        return {h, t, o[3:0]};
    endfunction

    // eight sprite pixels, MSB leftmost, placed from column x with wrap at 64
    function automatic logic [63:0] sprite_mask(input logic [7:0] bits, input logic [5:0] x);
        logic [63:0] m;
        logic [5:0]  col;
        m = '0;
        for (int c = 0; c < 8; c++) begin
            col = x + 6'(c);
            if (bits[7-c]) begin
                m[col] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

### hdl/chip8_interpreter_core.sv
// chip8_interpreter_core: CHIP-8 interpreter with memory, frame buffer, V file and
// return stack in synchronous RAMs, driven by one sequencer. Depends on chip8_pkg.
// One item in flight: item_ready is high only in S_IDLE, entered once the result is
// staged in S_RESP; a result not yet taken by result_ready stalls S_RESP. Reset: an
// S_INIT sweep loads the font into memory and clears the frame buffer and V file.
module chip8_interpreter_core
    import chip8_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int MA_W  = $clog2(MEM_BYTES);
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FONT_LAST = CNT_W'(FONT_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_ROW_LAST  = CNT_W'(SCREEN_ROWS - 1);
    localparam logic [CNT_W-1:0] CNT_BCD_LAST  = CNT_W'(2);

    // ---------------------------------------------------------------
    // Architectural and sequencer registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;
    item_t  item_reg, item_next;

    logic [11:0]      pc_reg, pc_next;
    logic [11:0]      idx_reg, idx_next;
    logic [7:0]       dt_reg, dt_next;
    logic [15:0]      keys_reg, keys_next;
    logic             wait_reg, wait_next;
    logic [3:0]       tgt_reg, tgt_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    logic [7:0]       op_hi_reg, op_hi_next;
    logic [7:0]       op_lo_reg, op_lo_next;
    logic [7:0]       vx_reg, vx_next;
    logic [7:0]       vy_reg, vy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic [7:0]       alu_reg, alu_next;
    logic [11:0]      bcd_reg, bcd_next;

    logic [2:0]       st_reg, st_next;
    logic             coll_reg, coll_next;
    logic [63:0]      row_reg, row_next;

    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    // ---------------------------------------------------------------
    // RAM ports
    // ---------------------------------------------------------------
    logic [7:0]  mem_ram [MEM_BYTES];
    logic        mem_we;
    logic [MA_W-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, mem_rd_reg;

    logic [63:0] fb_ram [SCREEN_ROWS];
    logic        fb_we;
    logic [ROW_W-1:0] fb_wa, fb_ra;
    logic [63:0] fb_wd, fb_rd_reg;

    logic [7:0]  v_ram [16];
    logic        v_we;
    logic [3:0]  v_wa, v_ra_a, v_ra_b;
    logic [7:0]  v_wd, va_rd_reg, vb_rd_reg;

    logic [11:0] stk_ram [STACK_DEPTH];
    logic        stk_we;
    logic [SP_W-1:0] stk_wa, stk_ra;
    logic [11:0] stk_wd, stk_rd_reg;

    // ---------------------------------------------------------------
    // Decode helpers
    // ---------------------------------------------------------------
    logic [3:0]  op_nib, x_idx, y_idx, n_val;
    logic [7:0]  nn;
    logic [11:0] nnn, pc_plus1, pc_plus2, pc_plus4, mem_off;
    logic [LVL_W-1:0] lvl_dec;
    logic [8:0]  sum9;
    logic        key_hit;
    logic [4:0]  lk;
    logic [63:0] smask;
    logic [ROW_W-1:0] draw_row;
    logic        accept;

    assign op_nib   = op_hi_reg[7:4];
    assign x_idx    = op_hi_reg[3:0];
    assign y_idx    = op_lo_reg[7:4];
    assign n_val    = op_lo_reg[3:0];
    assign nn       = op_lo_reg;
    assign nnn      = {x_idx, nn};
    assign pc_plus1 = pc_reg + 12'd1;
    assign pc_plus2 = pc_reg + 12'd2;
    assign pc_plus4 = pc_reg + 12'd4;
    assign mem_off  = idx_reg + {{(12-CNT_W){1'b0}}, cnt_reg};
    assign lvl_dec  = lvl_reg - {{(LVL_W-1){1'b0}}, 1'b1};
    assign sum9     = {1'b0, va_rd_reg} + {1'b0, vb_rd_reg};
    // keys above 15 count as released
    assign key_hit  = (va_rd_reg[7:4] == 4'h0) && keys_reg[va_rd_reg[3:0]];
    assign lk       = lowest_key(keys_reg);
    assign smask    = sprite_mask(mem_rd_reg, vx_reg[5:0]);
    assign draw_row = vy_reg[ROW_W-1:0] + cnt_reg[ROW_W-1:0];

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == CNT_FONT_LAST) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept) state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (item_reg.mode == MODE_ROW) state_next = S_ROW;
                else if (item_reg.mode == MODE_EXEC && !wait_reg) state_next = S_FETCH_HI;
                else state_next = S_RESP;
            end
            S_ROW:      state_next = S_RESP;
            S_FETCH_HI: state_next = S_FETCH_LO;
            S_FETCH_LO: state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_RESP;
                case (op_nib)
                    OP_SYS:
                    begin
                        if (nnn == SYS_CLS) state_next = S_CLEAR;
                        else if (nnn == SYS_RET && lvl_reg != '0) state_next = S_RET;
                    end
                    OP_ALU:
                    begin
                        if (n_val inside {ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL})
                            state_next = S_FLAG_WR;
                    end
                    OP_DRW:
                    begin
                        if (n_val != 4'h0) state_next = S_DRAW_RD;
                    end
                    OP_MISC:
                    begin
                        if (nn == F_BCD) state_next = S_BCD;
                        else if (nn == F_STORE) state_next = S_STORE_RD;
                        else if (nn == F_LOAD) state_next = S_LOAD_RD;
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_FLAG_WR: state_next = S_RESP;
            S_CLEAR:
            begin
                if (cnt_reg == CNT_ROW_LAST) state_next = S_RESP;
            end
            S_RET:     state_next = S_RESP;
            S_DRAW_RD: state_next = S_DRAW_WR;
            S_DRAW_WR:
            begin
                if ((cnt_reg + 7'd1) == {3'b000, n_val}) state_next = S_RESP;
                else state_next = S_DRAW_RD;
            end
            S_BCD:
            begin
                if (cnt_reg == CNT_BCD_LAST) state_next = S_RESP;
            end
            S_STORE_RD: state_next = S_STORE_WR;
            S_STORE_WR:
            begin
                if (cnt_reg[3:0] == x_idx) state_next = S_RESP;
                else state_next = S_STORE_RD;
            end
            S_LOAD_RD: state_next = S_LOAD_WR;
            S_LOAD_WR:
            begin
                if (cnt_reg[3:0] == x_idx) state_next = S_RESP;
                else state_next = S_LOAD_RD;
            end
            S_RESP:
            begin
                if (!out_valid_reg || result_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and RAM control
    // ---------------------------------------------------------------
    always_comb
    begin
        item_next  = item_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        dt_next    = dt_reg;
        keys_next  = keys_reg;
        wait_next  = wait_reg;
        tgt_next   = tgt_reg;
        lvl_next   = lvl_reg;
        op_hi_next = op_hi_reg;
        op_lo_next = op_lo_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        alu_next   = alu_reg;
        bcd_next   = bcd_reg;
        st_next    = st_reg;
        coll_next  = coll_reg;
        row_next   = row_reg;

        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;

        mem_we = 1'b0;
        mem_wa = mem_off[MA_W-1:0];
        mem_wd = 8'h00;
        mem_ra = pc_reg[MA_W-1:0];
        fb_we  = 1'b0;
        fb_wa  = draw_row;
        fb_wd  = fb_rd_reg ^ smask;
        fb_ra  = item_reg.row_select[ROW_W-1:0];
        v_we   = 1'b0;
        v_wa   = x_idx;
        v_wd   = 8'h00;
        v_ra_a = x_idx;
        v_ra_b = y_idx;
        stk_we = 1'b0;
        stk_wa = lvl_reg[SP_W-1:0];
        stk_wd = pc_plus2;
        stk_ra = lvl_dec[SP_W-1:0];

        case (state_reg)
            S_INIT:
            begin
                // font into RAM, frame buffer and V file to zero
                mem_we   = 1'b1;
                mem_wa   = MA_W'(cnt_reg);
                mem_wd   = FONT_ROM[cnt_reg];
                fb_we    = (cnt_reg < CNT_W'(SCREEN_ROWS));
                fb_wa    = cnt_reg[ROW_W-1:0];
                fb_wd    = '0;
                v_we     = (cnt_reg < 7'd16);
                v_wa     = cnt_reg[3:0];
                v_wd     = 8'h00;
                cnt_next = (cnt_reg == CNT_FONT_LAST) ? '0 : cnt_reg + 7'd1;
            end
            S_IDLE:
            begin
                if (accept) begin
                    item_next = item;
                    st_next   = ST_OK;
                    coll_next = 1'b0;
                    row_next  = '0;
                end
            end
            S_DISPATCH:
            begin
                mem_ra = pc_reg[MA_W-1:0];
                case (item_reg.mode)
                    MODE_LOAD:
                    begin
                        mem_we = 1'b1;
                        mem_wa = item_reg.address[MA_W-1:0];
                        mem_wd = item_reg.data;
                    end
                    MODE_KEY:  keys_next[item_reg.key_index] = item_reg.key_down;
                    MODE_TICK:
                    begin
                        if (dt_reg != 8'h00) dt_next = dt_reg - 8'd1;
                    end
                    MODE_EXEC:
                    begin
                        if (wait_reg) begin
                            if (lk[4]) begin
                                v_we      = 1'b1;
                                v_wa      = tgt_reg;
                                v_wd      = {4'h0, lk[3:0]};
                                wait_next = 1'b0;
                                st_next   = ST_OK;
                            end else begin
                                st_next = ST_WAIT;
                            end
                        end
                    end
                    default: st_next = ST_OK;
                endcase
            end
            S_ROW:      row_next = fb_rd_reg;
            S_FETCH_HI:
            begin
                op_hi_next = mem_rd_reg;
                mem_ra     = pc_plus1[MA_W-1:0];
            end
            S_FETCH_LO:
            begin
                op_lo_next = mem_rd_reg;
                v_ra_a     = x_idx;
                v_ra_b     = (op_nib == OP_JPV0) ? 4'h0 : mem_rd_reg[7:4];
            end
            S_EXEC:
            begin
                vx_next  = va_rd_reg;
                vy_next  = vb_rd_reg;
                cnt_next = '0;
                hit_next = 1'b0;
                pc_next  = pc_plus2;
                case (op_nib)
                    OP_SYS:
                    begin
                        if (nnn == SYS_RET) begin
                            if (lvl_reg == '0) st_next = ST_UNDER;
                            else lvl_next = lvl_dec;
                        end else if (nnn != SYS_CLS) begin
                            st_next = ST_BAD;
                        end
                    end
                    OP_JP:   pc_next = nnn;
                    OP_CALL:
                    begin
                        if (lvl_reg >= LVL_FULL) begin
                            st_next = ST_OVER;
                        end else begin
                            stk_we   = 1'b1;
                            lvl_next = lvl_reg + {{(LVL_W-1){1'b0}}, 1'b1};
                            pc_next  = nnn;
                        end
                    end
                    OP_SEQI: if (va_rd_reg == nn) pc_next = pc_plus4;
                    OP_SNEI: if (va_rd_reg != nn) pc_next = pc_plus4;
                    OP_SEQ:  if (va_rd_reg == vb_rd_reg) pc_next = pc_plus4;
                    OP_SNE:  if (va_rd_reg != vb_rd_reg) pc_next = pc_plus4;
                    OP_LDI:
                    begin
                        v_we = 1'b1;
                        v_wd = nn;
                    end
                    OP_ADDI:
                    begin
                        v_we = 1'b1;
                        v_wd = va_rd_reg + nn;
                    end
                    OP_ALU:
                    begin
                        // flag ops write VF here and Vx next cycle, so X=F keeps the result
                        v_wa = 4'hF;
                        case (n_val)
                            ALU_MOV:
                            begin
                                v_we = 1'b1; v_wa = x_idx; v_wd = vb_rd_reg;
                            end
                            ALU_OR:
                            begin
                                v_we = 1'b1; v_wa = x_idx; v_wd = va_rd_reg | vb_rd_reg;
                            end
                            ALU_AND:
                            begin
                                v_we = 1'b1; v_wa = x_idx; v_wd = va_rd_reg & vb_rd_reg;
                            end
                            ALU_XOR:
                            begin
                                v_we = 1'b1; v_wa = x_idx; v_wd = va_rd_reg ^ vb_rd_reg;
                            end
                            ALU_ADD:
                            begin
                                v_we = 1'b1; v_wd = {7'd0, sum9[8]}; alu_next = sum9[7:0];
                            end
                            ALU_SUB:
                            begin
                                v_we = 1'b1; v_wd = {7'd0, va_rd_reg > vb_rd_reg};
                                alu_next = va_rd_reg - vb_rd_reg;
                            end
                            ALU_SHR:
                            begin
                                v_we = 1'b1; v_wd = {7'd0, va_rd_reg[0]};
                                alu_next = {1'b0, va_rd_reg[7:1]};
                            end
                            ALU_SUBN:
                            begin
                                v_we = 1'b1; v_wd = {7'd0, vb_rd_reg > va_rd_reg};
                                alu_next = vb_rd_reg - va_rd_reg;
                            end
                            ALU_SHL:
                            begin
                                v_we = 1'b1; v_wd = {7'd0, va_rd_reg[7]};
                                alu_next = {va_rd_reg[6:0], 1'b0};
                            end
                            default: st_next = ST_BAD;
                        endcase
                    end
                    OP_LDIDX: idx_next = nnn;
                    OP_JPV0:  pc_next = nnn + {4'h0, vb_rd_reg};
                    OP_RND:
                    begin
                        v_we = 1'b1;
                        v_wd = nn & item_reg.random_byte;
                    end
                    OP_DRW:
                    begin
                        // zero-height sprite: nothing drawn, VF cleared
                        if (n_val == 4'h0) begin
                            v_we = 1'b1; v_wa = 4'hF; v_wd = 8'h00;
                        end
                    end
                    OP_KEY:
                    begin
                        if (nn == KEY_SKP) begin
                            if (key_hit) pc_next = pc_plus4;
                        end else if (nn == KEY_SKNP) begin
                            if (!key_hit) pc_next = pc_plus4;
                        end else begin
                            st_next = ST_BAD;
                        end
                    end
                    default:
                    begin
                        case (nn)
                            F_GETDT:
                            begin
                                v_we = 1'b1; v_wd = dt_reg;
                            end
                            F_WAITK:
                            begin
                                wait_next = 1'b1; tgt_next = x_idx; st_next = ST_WAIT;
                            end
                            F_SETDT: dt_next = va_rd_reg;
                            F_SETST: st_next = ST_OK;
                            F_ADDI:  idx_next = idx_reg + {4'h0, va_rd_reg};
                            F_FONT:  idx_next = {2'b00, va_rd_reg, 2'b00} + {4'h0, va_rd_reg};
                            F_BCD:   bcd_next = bcd_digits(va_rd_reg);
                            F_STORE: st_next = ST_OK;
                            F_LOAD:  st_next = ST_OK;
                            default: st_next = ST_BAD;
                        endcase
                    end
                endcase
            end
            S_FLAG_WR:
            begin
                v_we = 1'b1;
                v_wa = x_idx;
                v_wd = alu_reg;
            end
            S_CLEAR:
            begin
                fb_we    = 1'b1;
                fb_wa    = cnt_reg[ROW_W-1:0];
                fb_wd    = '0;
                cnt_next = cnt_reg + 7'd1;
            end
            S_RET:     pc_next = stk_rd_reg;
            S_DRAW_RD:
            begin
                mem_ra = mem_off[MA_W-1:0];
                fb_ra  = draw_row;
            end
            S_DRAW_WR:
            begin
                fb_we    = 1'b1;
                hit_next = hit_reg | (|(fb_rd_reg & smask));
                cnt_next = cnt_reg + 7'd1;
                if ((cnt_reg + 7'd1) == {3'b000, n_val}) begin
                    v_we      = 1'b1;
                    v_wa      = 4'hF;
                    v_wd      = {7'd0, hit_next};
                    coll_next = hit_next;
                end
            end
            S_BCD:
            begin
                mem_we = 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    mem_wd = {4'h0, bcd_reg[11:8]};
                    2'd1:    mem_wd = {4'h0, bcd_reg[7:4]};
                    default: mem_wd = {4'h0, bcd_reg[3:0]};
                endcase
                cnt_next = cnt_reg + 7'd1;
            end
            S_STORE_RD: v_ra_a = cnt_reg[3:0];
            S_STORE_WR:
            begin
                mem_we   = 1'b1;
                mem_wd   = va_rd_reg;
                cnt_next = cnt_reg + 7'd1;
            end
            S_LOAD_RD:  mem_ra = mem_off[MA_W-1:0];
            S_LOAD_WR:
            begin
                v_we     = 1'b1;
                v_wa     = cnt_reg[3:0];
                v_wd     = mem_rd_reg;
                cnt_next = cnt_reg + 7'd1;
            end
            S_RESP:
            begin
                if (!out_valid_reg || result_ready) begin
                    out_valid_next           = 1'b1;
                    out_next.status          = st_reg;
                    out_next.program_counter = pc_reg;
                    out_next.collision       = coll_reg;
                    out_next.display_row     = row_reg;
                    out_next.delay_value     = dt_reg;
                end
            end
            default: st_next = st_reg;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pc_reg        <= START_ADDR;
            idx_reg       <= '0;
            dt_reg        <= '0;
            keys_reg      <= '0;
            wait_reg      <= 1'b0;
            tgt_reg       <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            dt_reg        <= dt_next;
            keys_reg      <= keys_next;
            wait_reg      <= wait_next;
            tgt_reg       <= tgt_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        op_hi_reg <= op_hi_next;
        op_lo_reg <= op_lo_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        hit_reg   <= hit_next;
        alu_reg   <= alu_next;
        bcd_reg   <= bcd_next;
        st_reg    <= st_next;
        coll_reg  <= coll_next;
        row_reg   <= row_next;
        out_reg   <= out_next;
    end

    // ---------------------------------------------------------------
    // Memories: one write, registered read
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we) mem_ram[mem_wa] <= mem_wd;
        mem_rd_reg <= mem_ram[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fb_we) fb_ram[fb_wa] <= fb_wd;
        fb_rd_reg <= fb_ram[fb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (v_we) v_ram[v_wa] <= v_wd;
        va_rd_reg <= v_ram[v_ra_a];
        vb_rd_reg <= v_ram[v_ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we) stk_ram[stk_wa] <= stk_wd;
        stk_rd_reg <= stk_ram[stk_ra];
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_FULL)
        else $error("stack level beyond depth");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside response state");

    a_no_fetch_while_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH_HI) |-> !wait_reg)
        else $error("instruction fetched during key wait");

    a_draw_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW_WR) |-> (cnt_reg < {3'b000, n_val}))
        else $error("draw row count overran sprite height");

endmodule
